/* rtl/thsc_pkg.sv */
// Shared types, constants and the hold-time step function for the thermostat
// setpoint and countdown block. No dependencies.
package thsc_pkg;

  // Item kinds.
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FLOOR   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CEILING = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MARGIN  = 2'd2;

  localparam int TEMP_W = 12;

  // Reset values and fixed limits.
  localparam logic [TEMP_W-1:0] FLOOR_RESET    = 12'd40;
  localparam logic [TEMP_W-1:0] CEILING_RESET  = 12'd396;
  localparam logic [TEMP_W-1:0] MARGIN_RESET   = 12'd4;
  localparam logic [TEMP_W-1:0] SETPOINT_RESET = 12'd140;  // 35 degrees
  localparam logic [7:0]        HOLD_MAX       = 8'd255;
  localparam logic [3:0]        TENTHS_RELOAD  = 4'd9;
  localparam logic [3:0]        HEATER_ABOVE   = 4'd5;
  localparam logic [5:0]        SECONDS_RELOAD = 6'd59;
  localparam logic [5:0]        MINUTES_RELOAD = 6'd59;
  localparam logic [2:0]        POWER_OFF      = 3'd0;
  localparam logic [2:0]        POWER_FULL     = 3'd5;

  typedef struct packed {
    logic              opcode;
    logic              down_pressed;
    logic              up_pressed;
    logic [TEMP_W-1:0] measured_temp;
  } item_t;

  // Timer and power view after one item.
  typedef struct packed {
    logic       heater_on;
    logic [2:0] power_level;
    logic       hours_left;
    logic [5:0] minutes_left;
    logic [5:0] seconds_left;
    logic [3:0] tenths_left;
    logic       redraw_strobe;
  } timer_view_t;

  // Setpoint step for a button held for h ticks, given tenths before the tick.
  function automatic logic [2:0] hold_step(logic [7:0] h, logic [3:0] tenths);
    logic [2:0] s;
    if (h == 8'd1) begin
      s = 3'd1;
    end else if (h < 8'd8) begin
      s = 3'd0;
    end else if (h < 8'd16) begin
      s = (tenths[1:0] == 2'd0) ? 3'd1 : 3'd0;
    end else if (h < 8'd32) begin
      s = (tenths[0] == 1'b0) ? 3'd1 : 3'd0;
    end else begin
      s = h[7:5];
    end
    return s;
  endfunction

endpackage

/* rtl/thsc_setpoint.sv */
// Setpoint state: the target temperature and the two button hold counters.
// Depends on thsc_pkg for the item type, constants and hold_step.
module thsc_setpoint (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  thsc_pkg::item_t             item,
  input  logic [3:0]                  tenths,
  input  logic [thsc_pkg::TEMP_W-1:0] floor_val,
  input  logic [thsc_pkg::TEMP_W-1:0] ceiling_val,
  output logic [thsc_pkg::TEMP_W-1:0] target_next,
  output logic                        save_next
);

  logic [thsc_pkg::TEMP_W-1:0] target;
  logic [7:0]                  hold_down;
  logic [7:0]                  hold_up;
  logic [7:0]                  hold_down_next;
  logic [7:0]                  hold_up_next;
  logic [2:0]                  step_down;
  logic [2:0]                  step_up;
  logic signed [13:0]          sum;

  assign step_down = (hold_down != 8'd0) ? thsc_pkg::hold_step(hold_down, tenths) : 3'd0;
  assign step_up   = (hold_up != 8'd0) ? thsc_pkg::hold_step(hold_up, tenths) : 3'd0;

  always_comb begin
    target_next    = target;
    save_next      = 1'b0;
    hold_down_next = hold_down;
    hold_up_next   = hold_up;
    sum = $signed({2'b00, target}) - $signed({11'd0, step_down})
        + $signed({11'd0, step_up});
    if (item.opcode == thsc_pkg::OP_SAMPLE) begin
      if (!item.down_pressed) begin
        hold_down_next = 8'd0;
      end else if (hold_down == 8'd0) begin
        hold_down_next = 8'd1;
      end
      if (!item.up_pressed) begin
        hold_up_next = 8'd0;
      end else if (hold_up == 8'd0) begin
        hold_up_next = 8'd1;
      end
    end else begin
      save_next = (hold_down != 8'd0) || (hold_up != 8'd0);
      // When the window is inverted, the floor wins only if the sum is below it.
      if (sum < $signed({2'b00, floor_val})) begin
        target_next = floor_val;
      end else if (sum > $signed({2'b00, ceiling_val})) begin
        target_next = ceiling_val;
      end else begin
        target_next = sum[thsc_pkg::TEMP_W-1:0];
      end
      // Hold counters grow only on ticks that do not reload tenths.
      if (tenths != 4'd0) begin
        if (hold_down != 8'd0 && hold_down != thsc_pkg::HOLD_MAX) begin
          hold_down_next = hold_down + 8'd1;
        end
        if (hold_up != 8'd0 && hold_up != thsc_pkg::HOLD_MAX) begin
          hold_up_next = hold_up + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target    <= thsc_pkg::SETPOINT_RESET;
      hold_down <= 8'd0;
      hold_up   <= 8'd0;
    end else if (advance) begin
      target    <= target_next;
      hold_down <= hold_down_next;
      hold_up   <= hold_up_next;
    end
  end

endmodule

/* rtl/thsc_timer.sv */
// Countdown timer, heater pin, last measured temperature and power level.
// Depends on thsc_pkg for the item and view types and constants.
module thsc_timer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  thsc_pkg::item_t             item,
  input  logic [thsc_pkg::TEMP_W-1:0] target_next,
  input  logic [thsc_pkg::TEMP_W-1:0] margin_val,
  output logic [3:0]                  tenths,
  output thsc_pkg::timer_view_t       view_next
);

  logic [thsc_pkg::TEMP_W-1:0] last_temp;
  logic [thsc_pkg::TEMP_W-1:0] last_temp_next;
  logic [thsc_pkg::TEMP_W-1:0] shortfall;
  thsc_pkg::timer_view_t       view;

  assign shortfall = target_next - last_temp;

  always_comb begin
    view_next               = view;
    view_next.redraw_strobe = 1'b0;
    last_temp_next          = last_temp;
    if (item.opcode == thsc_pkg::OP_SAMPLE) begin
      last_temp_next = item.measured_temp;
    end else begin
      view_next.heater_on = (tenths > thsc_pkg::HEATER_ABOVE);
      if (tenths != 4'd0) begin
        view_next.tenths_left = tenths - 4'd1;
      end else begin
        view_next.tenths_left = thsc_pkg::TENTHS_RELOAD;
        if (target_next <= last_temp) begin
          view_next.power_level = thsc_pkg::POWER_OFF;
        end else if (shortfall > margin_val) begin
          view_next.power_level = thsc_pkg::POWER_FULL;
        end
        if (view.seconds_left != 6'd0) begin
          view_next.seconds_left = view.seconds_left - 6'd1;
        end else begin
          view_next.seconds_left = thsc_pkg::SECONDS_RELOAD;
          if (view.minutes_left != 6'd0) begin
            view_next.minutes_left = view.minutes_left - 6'd1;
          end else begin
            view_next.minutes_left = thsc_pkg::MINUTES_RELOAD;
            // Hours count down from one and reload to one below zero.
            view_next.hours_left = ~view.hours_left;
          end
        end
      end
      view_next.redraw_strobe = ~view_next.tenths_left[0];
    end
  end

  assign tenths = view.tenths_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_temp          <= '0;
      view.heater_on     <= 1'b1;
      view.power_level   <= thsc_pkg::POWER_OFF;
      view.hours_left    <= 1'b1;
      view.minutes_left  <= 6'd0;
      view.seconds_left  <= 6'd0;
      view.tenths_left   <= 4'd0;
      view.redraw_strobe <= 1'b0;
    end else if (advance) begin
      last_temp <= last_temp_next;
      view      <= view_next;
    end
  end

endmodule

/* rtl/thermostat_setpoint_and_countdown_top.sv */
// Top level of the thermostat setpoint and countdown block: configuration
// registers, input register, result register. Uses thsc_pkg, thsc_setpoint, thsc_timer.
// An accepted request is held in the input register, then moves into the output register
// to be taken; one request per cycle is sustained while results are taken, and the
// input stalls only while both registers are full and the result is stalled.
// Reset (rst, synchronous, active high) restores defaults, setpoint 140, heater pin set.
module thermostat_setpoint_and_countdown_top (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration write port.
  input  logic                               cfg_wr_en,
  input  logic [thsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [thsc_pkg::TEMP_W-1:0]        cfg_data,
  // Input channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               opcode,
  input  logic                               down_pressed,
  input  logic                               up_pressed,
  input  logic [thsc_pkg::TEMP_W-1:0]        measured_temp,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [thsc_pkg::TEMP_W-1:0]        setpoint,
  output logic                               heater_on,
  output logic [2:0]                         power_level,
  output logic                               hours_left,
  output logic [5:0]                         minutes_left,
  output logic [5:0]                         seconds_left,
  output logic [3:0]                         tenths_left,
  output logic                               save_strobe,
  output logic                               redraw_strobe
);

  // Configuration registers. Writes to an index past the list are dropped.
  logic [thsc_pkg::TEMP_W-1:0] floor_val;
  logic [thsc_pkg::TEMP_W-1:0] ceiling_val;
  logic [thsc_pkg::TEMP_W-1:0] margin_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_val   <= thsc_pkg::FLOOR_RESET;
      ceiling_val <= thsc_pkg::CEILING_RESET;
      margin_val  <= thsc_pkg::MARGIN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        thsc_pkg::CFG_FLOOR:   floor_val   <= cfg_data;
        thsc_pkg::CFG_CEILING: ceiling_val <= cfg_data;
        thsc_pkg::CFG_MARGIN:  margin_val  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The input register holds one request while the result register is
  // stalled, so the input side takes one more request while a result waits.
  logic            in_q_valid;
  thsc_pkg::item_t in_q;
  logic            out_free;
  logic            advance;
  logic            in_accept;

  assign out_free  = !out_valid || !out_stall;
  assign advance   = in_q_valid && out_free;
  assign in_stall  = in_q_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_q.opcode        <= opcode;
      in_q.down_pressed  <= down_pressed;
      in_q.up_pressed    <= up_pressed;
      in_q.measured_temp <= measured_temp;
    end
  end

  // State updates happen as the registered request moves into the result
  // register; the setpoint unit feeds the new target to the power decision.
  logic [thsc_pkg::TEMP_W-1:0] target_next;
  logic                        save_next;
  logic [3:0]                  tenths;
  thsc_pkg::timer_view_t       view_next;

  thsc_setpoint u_setpoint (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (in_q),
    .tenths      (tenths),
    .floor_val   (floor_val),
    .ceiling_val (ceiling_val),
    .target_next (target_next),
    .save_next   (save_next)
  );

  thsc_timer u_timer (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (in_q),
    .target_next (target_next),
    .margin_val  (margin_val),
    .tenths      (tenths),
    .view_next   (view_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      setpoint      <= target_next;
      heater_on     <= view_next.heater_on;
      power_level   <= view_next.power_level;
      hours_left    <= view_next.hours_left;
      minutes_left  <= view_next.minutes_left;
      seconds_left  <= view_next.seconds_left;
      tenths_left   <= view_next.tenths_left;
      save_strobe   <= save_next;
      redraw_strobe <= view_next.redraw_strobe;
    end
  end

  // A request held in the input register is not dropped while the result waits.
  a_hold_request: assert property (@(posedge clk) disable iff (rst)
    (in_q_valid && !out_free) |=> in_q_valid)
    else $error("input register lost a request while stalled");

  // Delivered counters stay in their digit ranges.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tenths_left <= 4'd9 && seconds_left <= 6'd59 && minutes_left <= 6'd59))
    else $error("countdown digit out of range");

  // Power only takes the off or full level.
  a_power_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (power_level == thsc_pkg::POWER_OFF || power_level == thsc_pkg::POWER_FULL))
    else $error("unexpected power level");

  // A sample request never raises either strobe.
  a_sample_quiet: assert property (@(posedge clk) disable iff (rst)
    (advance && in_q.opcode == thsc_pkg::OP_SAMPLE) |=> (!save_strobe && !redraw_strobe))
    else $error("strobe raised by a sample request");

endmodule

/* test/thermostat_setpoint_and_countdown_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for thermostat_setpoint_and_countdown_top: a queue-fed driver,
// a checking monitor and a behavioral model of setpoint, power and countdown logic.
// Depends on rtl/thsc_pkg.sv and the RTL of the block.
module thermostat_setpoint_and_countdown_top_tb;

  localparam int TEMP_W      = thsc_pkg::TEMP_W;
  localparam int CFG_INDEX_W = thsc_pkg::CFG_INDEX_W;

  // No acceptance on either channel for this many cycles means the block is hung.
  localparam int WATCHDOG_LIMIT   = 4000;
  // Length of the one long receiver hold-off that backs the block up.
  localparam int LONG_HOLD_CYCLES = 300;
  // Cycles allowed after the last result before a register write or the verdict.
  localparam int DRAIN_CYCLES     = 4;

  // One result as the block reports it.
  typedef struct packed {
    logic [TEMP_W-1:0] setpoint;
    logic              heater_on;
    logic [2:0]        power_level;
    logic              hours_left;
    logic [5:0]        minutes_left;
    logic [5:0]        seconds_left;
    logic [3:0]        tenths_left;
    logic              save_strobe;
    logic              redraw_strobe;
  } reading_t;

  // Clock, reset and block ports. Every input starts at a known value.
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = thsc_pkg::CFG_FLOOR;
  logic [TEMP_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              opcode = thsc_pkg::OP_TICK;
  logic              down_pressed = 1'b0;
  logic              up_pressed = 1'b0;
  logic [TEMP_W-1:0] measured_temp = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [TEMP_W-1:0] setpoint;
  logic              heater_on;
  logic [2:0]        power_level;
  logic              hours_left;
  logic [5:0]        minutes_left;
  logic [5:0]        seconds_left;
  logic [3:0]        tenths_left;
  logic              save_strobe;
  logic              redraw_strobe;

  thermostat_setpoint_and_countdown_top dut (.*);

  always #4 clk = ~clk;

  // Model copy of the configuration registers.
  logic [TEMP_W-1:0] floor_q, ceiling_q, margin_q;
  // Model copy of the block state.
  logic [TEMP_W-1:0] sp_target;
  logic [7:0]        hold_ticks [2];  // index 0 is the down button, 1 the up button
  logic [TEMP_W-1:0] last_meas;
  logic [2:0]        power_lvl;
  logic [3:0]        tenths_q;
  logic [5:0]        seconds_q, minutes_q;
  logic              hours_q;
  logic              heater_q;

  // Requests waiting to be offered, and readings predicted for accepted requests.
  thsc_pkg::item_t pending_requests[$];
  reading_t        predicted_readings[$];
  thsc_pkg::item_t cur_request;
  reading_t        fresh, want;

  // Traffic shaping, set per phase by the sequencer.
  int idle_pct = 0;
  int stall_pct = 0;
  logic long_hold_req = 1'b0;
  logic long_hold_taken = 1'b0;
  int hold_left = 0;

  int mismatches = 0;
  int idle_cycles = 0;

  // Setpoint increment for a button held for h ticks, judged on the tenths
  // digit as it stood before the tick counts down.
  function automatic logic [2:0] hold_increment(logic [7:0] h, logic [3:0] tenths);
    if (h == 8'd1) return 3'd1;
    if (h < 8'd8) return 3'd0;
    if (h < 8'd16) return {2'b00, tenths[1:0] == 2'b00};
    if (h < 8'd32) return {2'b00, ~tenths[0]};
    return h[7:5];
  endfunction

  // Applies one accepted request to the model state and returns the reading
  // that the block must report for it.
  task automatic advance_thermostat(input thsc_pkg::item_t it, output reading_t r);
    int   t;
    int   k;
    logic held [2];
    r.save_strobe   = 1'b0;
    r.redraw_strobe = 1'b0;
    if (it.opcode == thsc_pkg::OP_SAMPLE) begin
      // A sample only latches the buttons and the temperature.
      held[0] = it.down_pressed;
      held[1] = it.up_pressed;
      for (k = 0; k < 2; k++) begin
        if (!held[k]) begin
          hold_ticks[k] = 8'd0;
        end else if (hold_ticks[k] == 8'd0) begin
          hold_ticks[k] = 8'd1;
        end
      end
      last_meas = it.measured_temp;
    end else begin
      // The sum is formed without wrap and then clamped; a floor above the
      // ceiling wins whenever the value is below it.
      t = int'(sp_target);
      if (hold_ticks[0] != 8'd0) begin
        t = t - int'(hold_increment(hold_ticks[0], tenths_q));
        r.save_strobe = 1'b1;
      end
      if (hold_ticks[1] != 8'd0) begin
        t = t + int'(hold_increment(hold_ticks[1], tenths_q));
        r.save_strobe = 1'b1;
      end
      if (t < int'(floor_q)) begin
        t = int'(floor_q);
      end else if (t > int'(ceiling_q)) begin
        t = int'(ceiling_q);
      end
      sp_target = t[TEMP_W-1:0];
      heater_q = (tenths_q > thsc_pkg::HEATER_ABOVE);
      if (tenths_q != 4'd0) begin
        tenths_q = tenths_q - 4'd1;
        // Hold counts only grow on ticks that do not reload tenths.
        for (k = 0; k < 2; k++) begin
          if (hold_ticks[k] != 8'd0 && hold_ticks[k] != thsc_pkg::HOLD_MAX) begin
            hold_ticks[k] = hold_ticks[k] + 8'd1;
          end
        end
      end else begin
        tenths_q = thsc_pkg::TENTHS_RELOAD;
        // Power is revisited once a second; a small shortfall keeps the old level.
        if (sp_target <= last_meas) begin
          power_lvl = thsc_pkg::POWER_OFF;
        end else if (sp_target - last_meas > margin_q) begin
          power_lvl = thsc_pkg::POWER_FULL;
        end
        if (seconds_q != 6'd0) begin
          seconds_q = seconds_q - 6'd1;
        end else begin
          seconds_q = thsc_pkg::SECONDS_RELOAD;
          if (minutes_q != 6'd0) begin
            minutes_q = minutes_q - 6'd1;
          end else begin
            // The one-bit hours digit counts 1 down to 0 and reloads to 1 from 0.
            minutes_q = thsc_pkg::MINUTES_RELOAD;
            hours_q = ~hours_q;
          end
        end
      end
      r.redraw_strobe = ~tenths_q[0];
    end
    r.setpoint     = sp_target;
    r.heater_on    = heater_q;
    r.power_level  = power_lvl;
    r.hours_left   = hours_q;
    r.minutes_left = minutes_q;
    r.seconds_left = seconds_q;
    r.tenths_left  = tenths_q;
  endtask

  task automatic check_field(input string name, input logic [TEMP_W-1:0] exp_v,
                             input logic [TEMP_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // Temperatures spread over the whole range, the default window, and the
  // edges of the current window where the power decision is close.
  function automatic logic [TEMP_W-1:0] pick_temp();
    logic [TEMP_W-1:0] jitter;
    jitter = TEMP_W'($urandom_range(16)) - TEMP_W'(8);
    case ($urandom_range(3))
      0: return TEMP_W'($urandom_range(4095));
      1: return TEMP_W'($urandom_range(511));
      2: return ceiling_q + jitter;
      default: return floor_q + jitter;
    endcase
  endfunction

  // A tick ignores its button and temperature fields, so those are random.
  task automatic push_tick();
    thsc_pkg::item_t it;
    it.opcode        = thsc_pkg::OP_TICK;
    it.down_pressed  = 1'($urandom_range(1));
    it.up_pressed    = 1'($urandom_range(1));
    it.measured_temp = TEMP_W'($urandom_range(4095));
    pending_requests.push_back(it);
  endtask

  task automatic push_sample(input logic dn, input logic up, input logic [TEMP_W-1:0] temp);
    thsc_pkg::item_t it;
    it.opcode        = thsc_pkg::OP_SAMPLE;
    it.down_pressed  = dn;
    it.up_pressed    = up;
    it.measured_temp = temp;
    pending_requests.push_back(it);
  endtask

  // Mostly press-hold-release sequences, so that hold counts climb through the
  // step tiers and now and then saturate; the rest are stray requests.
  task automatic queue_random_items(input int count);
    int   made;
    int   run;
    int   k;
    logic dn, up;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 70) begin
        dn = 1'($urandom_range(1));
        up = (dn == 1'b0) ? 1'b1 : 1'($urandom_range(1));
        push_sample(dn, up, pick_temp());
        run = ($urandom_range(19) == 0) ? $urandom_range(320, 200) : $urandom_range(30, 1);
        for (k = 0; k < run; k++) begin
          if ($urandom_range(15) == 0) begin
            push_sample(dn, up, pick_temp());
          end else begin
            push_tick();
          end
        end
        push_sample(1'b0, 1'b0, pick_temp());
        made = made + run + 2;
      end else begin
        if ($urandom_range(1) == 0) begin
          push_sample(1'($urandom_range(1)), 1'($urandom_range(1)), pick_temp());
        end else begin
          push_tick();
        end
        made++;
      end
    end
  endtask

  // Register writes happen only while the block is empty, so the model copy is
  // updated at once.
  task automatic program_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [TEMP_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      thsc_pkg::CFG_FLOOR:   floor_q   = value;
      thsc_pkg::CFG_CEILING: ceiling_q = value;
      thsc_pkg::CFG_MARGIN:  margin_q  = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Waits until every queued request has been accepted and answered, then lets
  // the pipeline settle before returning.
  task automatic wait_until_drained();
    while (pending_requests.size() != 0 || in_valid || predicted_readings.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Request driver. A request is offered when the slot is free (nothing offered,
  // or the offered request is taken at this edge); a stalled request is held
  // unchanged. The accepted request is run through the model right here.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        advance_thermostat(cur_request, fresh);
        predicted_readings.push_back(fresh);
      end
      if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur_request = pending_requests.pop_front();
        in_valid      <= 1'b1;
        opcode        <= cur_request.opcode;
        down_pressed  <= cur_request.down_pressed;
        up_pressed    <= cur_request.up_pressed;
        measured_temp <= cur_request.measured_temp;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor. Each accepted result is checked against the oldest
  // prediction, and the stall for the next cycle is chosen. The one long
  // hold-off is counted here so that the sender keeps pushing meanwhile.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_readings.size() == 0) begin
          $error("result delivered with no request outstanding");
          mismatches++;
        end else begin
          want = predicted_readings.pop_front();
          check_field("setpoint", want.setpoint, setpoint);
          check_field("heater_on", TEMP_W'(want.heater_on), TEMP_W'(heater_on));
          check_field("power_level", TEMP_W'(want.power_level), TEMP_W'(power_level));
          check_field("hours_left", TEMP_W'(want.hours_left), TEMP_W'(hours_left));
          check_field("minutes_left", TEMP_W'(want.minutes_left), TEMP_W'(minutes_left));
          check_field("seconds_left", TEMP_W'(want.seconds_left), TEMP_W'(seconds_left));
          check_field("tenths_left", TEMP_W'(want.tenths_left), TEMP_W'(tenths_left));
          check_field("save_strobe", TEMP_W'(want.save_strobe), TEMP_W'(save_strobe));
          check_field("redraw_strobe", TEMP_W'(want.redraw_strobe), TEMP_W'(redraw_strobe));
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else if (long_hold_req && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: a stretch with no request taken and no result taken means a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("thermostat_setpoint_and_countdown_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sequencer: reset, then phases that each pick a register setting and a
  // traffic pattern and queue their requests.
  initial begin
    floor_q       = thsc_pkg::FLOOR_RESET;
    ceiling_q     = thsc_pkg::CEILING_RESET;
    margin_q      = thsc_pkg::MARGIN_RESET;
    sp_target     = thsc_pkg::SETPOINT_RESET;
    hold_ticks[0] = 8'd0;
    hold_ticks[1] = 8'd0;
    last_meas     = '0;
    power_lvl     = thsc_pkg::POWER_OFF;
    tenths_q      = 4'd0;
    seconds_q     = 6'd0;
    minutes_q     = 6'd0;
    hours_q       = 1'b1;
    heater_q      = 1'b1;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed opening at reset settings with no idling. The first tick
    // reloads every digit at once and wraps the minutes, taking hours to zero.
    // Both buttons held cancel out while the save strobe still fires; a
    // temperature at full scale forces power off at the next whole second.
    push_tick();
    push_sample(1'b1, 1'b1, 12'hFFF);
    repeat (11) push_tick();
    push_sample(1'b0, 1'b1, 12'h000);
    repeat (3) push_tick();
    push_sample(1'b1, 1'b0, 12'hAAA);
    repeat (2) push_tick();
    push_sample(1'b0, 1'b0, 12'h555);
    push_tick();
    push_sample(1'b0, 1'b0, thsc_pkg::SETPOINT_RESET);
    queue_random_items(100);
    wait_until_drained();

    // Widest window and zero margin; the sender idles most of the time.
    program_register(thsc_pkg::CFG_FLOOR, 12'd0);
    program_register(thsc_pkg::CFG_CEILING, 12'd4095);
    program_register(thsc_pkg::CFG_MARGIN, 12'd0);
    idle_pct  = 62;
    stall_pct = 0;
    queue_random_items(120);
    wait_until_drained();

    // Floor above the ceiling and the largest margin; the receiver stalls often.
    program_register(thsc_pkg::CFG_FLOOR, 12'd4095);
    program_register(thsc_pkg::CFG_CEILING, 12'd0);
    program_register(thsc_pkg::CFG_MARGIN, 12'd4095);
    idle_pct  = 0;
    stall_pct = 62;
    queue_random_items(100);
    wait_until_drained();

    // A window of one value; both sides idle a little.
    program_register(thsc_pkg::CFG_FLOOR, 12'd2048);
    program_register(thsc_pkg::CFG_CEILING, 12'd2048);
    program_register(thsc_pkg::CFG_MARGIN, 12'd1);
    idle_pct  = 16;
    stall_pct = 16;
    queue_random_items(100);
    wait_until_drained();

    // Random window. The receiver holds off for a long stretch while the
    // sender keeps offering, so the block backs up and stalls its input.
    program_register(thsc_pkg::CFG_FLOOR, TEMP_W'($urandom_range(400)));
    program_register(thsc_pkg::CFG_CEILING, TEMP_W'($urandom_range(4095, int'(floor_q))));
    program_register(thsc_pkg::CFG_MARGIN, TEMP_W'($urandom_range(64)));
    idle_pct  = 0;
    stall_pct = 0;
    long_hold_req = 1'b1;
    queue_random_items(120);
    wait_until_drained();

    // Back to the reset settings, receiver stalling often.
    program_register(thsc_pkg::CFG_FLOOR, thsc_pkg::FLOOR_RESET);
    program_register(thsc_pkg::CFG_CEILING, thsc_pkg::CEILING_RESET);
    program_register(thsc_pkg::CFG_MARGIN, thsc_pkg::MARGIN_RESET);
    idle_pct  = 0;
    stall_pct = 62;
    queue_random_items(120);
    wait_until_drained();

    if (mismatches == 0) begin
      $display("thermostat_setpoint_and_countdown_top regression: pass");
    end else begin
      $display("thermostat_setpoint_and_countdown_top regression: fail");
    end
    $finish;
  end

endmodule
